@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bol_pkg.sv @@
// ----------------------------------------------------------------------------
// bol_pkg
// Operation codes, result status codes and sequencer states of the bounded
// ordered list unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bol_pkg;

    localparam int unsigned FUNC_W = 2;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OCC_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_DELETE     = 2'd2,
        OP_SEARCH     = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RESULT
    } state_t;

endpackage

`default_nettype wire

@@ rtl/bol_ram.sv @@
// ----------------------------------------------------------------------------
// bol_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bol_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/bounded_ordered_list_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_ordered_list_unit
// Ordered list of up to DEPTH 32-bit values with push front, push back,
// delete first match and search, run by a small sequencer over one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command beat: drive func and value and raise start while busy is low; the
//   beat is taken at that edge and busy rises on the next cycle.
//   Result beat: done is high for exactly one cycle with found, status and
//   occupancy; the receiver cannot stall it, so sample it then.
//   Entries live in a circular buffer in a single RAM with a head pointer, so
//   push front and push back are one write each. Delete and search walk the
//   list with one shared 32-bit comparator, reading each entry visited from
//   the RAM and then comparing it. Delete of an inner entry closes the gap by
//   copying the tail down one slot, each moved entry read and then written;
//   deleting the front entry only advances the head.
//   The next command is taken on the cycle after done.
// Reset: empties the list (count and head cleared); RAM contents are left as
//   they are, since only slots below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bounded_ordered_list_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [bol_pkg::FUNC_W-1:0]    func,
    input  wire logic signed [bol_pkg::DATA_W-1:0] value,
    output logic                               done,
    output logic                               found,
    output logic      [bol_pkg::STAT_W-1:0]    status,
    output logic      [bol_pkg::OCC_W-1:0]     occupancy
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_W = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // Map a logical position onto a RAM slot: head plus offset, wrapped once.
    function automatic logic [IDX_W-1:0] wrap_add(
        input logic [IDX_W-1:0] base,
        input logic [IDX_W-1:0] offs
    );
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[IDX_W-1:0];
    endfunction

    // Sequencer and datapath registers
    bol_pkg::state_t  state_reg,  state_next;
    bol_pkg::op_t     op_reg,     op_next;
    bol_pkg::status_t status_reg, status_next;
    logic                       found_reg,  found_next;
    logic [bol_pkg::DATA_W-1:0] key_reg,    key_next;
    logic [IDX_W-1:0]           idx_reg,    idx_next;
    logic [IDX_W-1:0]           head_reg,   head_next;
    logic [CNT_W-1:0]           count_reg,  count_next;

    // RAM port signals
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    logic [bol_pkg::DATA_W-1:0] ram_wdata;
    logic [IDX_W-1:0]           ram_raddr;
    logic [bol_pkg::DATA_W-1:0] ram_rdata;

    // Shared address and compare logic
    logic [IDX_W-1:0] phys_idx;
    logic [IDX_W-1:0] phys_nxt;
    logic [IDX_W-1:0] phys_tail;
    logic [IDX_W-1:0] head_dec;
    logic [CNT_W-1:0] idx_inc;
    logic             hit;
    logic             list_full;
    logic             scan_last;
    logic             shift_last;
    logic             del_no_move;

    assign phys_idx    = wrap_add(head_reg, idx_reg);
    assign phys_nxt    = wrap_add(head_reg, idx_reg + 1'b1);
    assign phys_tail   = wrap_add(head_reg, IDX_W'(count_reg));
    assign head_dec    = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign idx_inc     = CNT_W'(idx_reg) + 1'b1;
    assign hit         = (ram_rdata == key_reg);
    assign list_full   = (count_reg == FULL_CNT);
    assign scan_last   = (idx_inc == count_reg);
    assign shift_last  = ((idx_inc + 1'b1) == count_reg);
    // Front or back entry: no tail to move.
    assign del_no_move = (idx_reg == '0) || scan_last;

    bol_ram #(
        .WIDTH (bol_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bol_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = bol_pkg::S_DISPATCH;
                end
            end
            bol_pkg::S_DISPATCH:
            begin
                case (op_reg) inside
                    bol_pkg::OP_PUSH_FRONT, bol_pkg::OP_PUSH_BACK:
                        state_next = bol_pkg::S_RESULT;
                    default:
                        state_next = (count_reg == '0) ? bol_pkg::S_RESULT
                                                       : bol_pkg::S_SCAN_RD;
                endcase
            end
            bol_pkg::S_SCAN_RD:
            begin
                state_next = bol_pkg::S_SCAN_CMP;
            end
            bol_pkg::S_SCAN_CMP:
            begin
                if (hit)
                begin
                    if (op_reg == bol_pkg::OP_SEARCH || del_no_move)
                    begin
                        state_next = bol_pkg::S_RESULT;
                    end
                    else
                    begin
                        state_next = bol_pkg::S_SHIFT_RD;
                    end
                end
                else if (scan_last)
                begin
                    state_next = bol_pkg::S_RESULT;
                end
                else
                begin
                    state_next = bol_pkg::S_SCAN_RD;
                end
            end
            bol_pkg::S_SHIFT_RD:
            begin
                state_next = bol_pkg::S_SHIFT_WR;
            end
            bol_pkg::S_SHIFT_WR:
            begin
                state_next = shift_last ? bol_pkg::S_RESULT : bol_pkg::S_SHIFT_RD;
            end
            bol_pkg::S_RESULT:
            begin
                state_next = bol_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bol_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        op_next     = op_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        found_next  = found_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = phys_idx;
        ram_wdata   = key_reg;
        ram_raddr   = phys_idx;

        unique case (state_reg)
            bol_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next     = bol_pkg::op_t'(func);
                    key_next    = value;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    status_next = bol_pkg::ST_DONE;
                end
            end
            bol_pkg::S_DISPATCH:
            begin
                unique case (op_reg)
                    bol_pkg::OP_PUSH_FRONT:
                    begin
                        if (list_full)
                        begin
                            status_next = bol_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = head_dec;
                            head_next  = head_dec;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    bol_pkg::OP_PUSH_BACK:
                    begin
                        if (list_full)
                        begin
                            status_next = bol_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = phys_tail;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    bol_pkg::OP_DELETE,
                    bol_pkg::OP_SEARCH:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bol_pkg::ST_ABSENT;
                        end
                    end
                endcase
            end
            bol_pkg::S_SCAN_RD:
            begin
                ram_raddr = phys_idx;
            end
            bol_pkg::S_SCAN_CMP:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    if (op_reg == bol_pkg::OP_DELETE && del_no_move)
                    begin
                        // Drop the front by advancing the head; drop the back
                        // by shrinking the count alone.
                        if (idx_reg == '0)
                        begin
                            head_next = phys_nxt;
                        end
                        count_next = count_reg - 1'b1;
                    end
                end
                else if (scan_last)
                begin
                    status_next = bol_pkg::ST_ABSENT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            bol_pkg::S_SHIFT_RD:
            begin
                ram_raddr = phys_nxt;
            end
            bol_pkg::S_SHIFT_WR:
            begin
                // Move the entry behind the gap down one slot.
                ram_we    = 1'b1;
                ram_waddr = phys_idx;
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + 1'b1;
                if (shift_last)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            bol_pkg::S_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bol_pkg::S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            status_reg <= bol_pkg::ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    // Command payload
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
    end

    // Outputs: hold busy for the whole command; present the result beat for
    // one cycle.
    assign busy      = (state_reg != bol_pkg::S_IDLE);
    assign done      = (state_reg == bol_pkg::S_RESULT);
    assign found     = found_reg;
    assign status    = status_reg;
    assign occupancy = bol_pkg::OCC_W'(count_reg);

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= FULL_CNT, "count above DEPTH")
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done, "command not held")
    `ASSERT_NEXT(a_done_release, clk, rst_n, done, !busy && !done, "result beat not single")
    `ASSERT_IMPLY(a_full_count, clk, rst_n, done && status_reg == bol_pkg::ST_FULL, list_full, "full status with room left")
    `ASSERT_IMPLY(a_found_ok, clk, rst_n, done && found_reg, status_reg == bol_pkg::ST_DONE, "found with error status")

endmodule

`default_nettype wire

@@ bench/bounded_ordered_list_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_checker
// Watches the command and result beats of the bounded ordered list unit,
// keeps a shadow copy of the list, and compares every result beat with the
// outcome predicted when its command beat was taken.
// ----------------------------------------------------------------------------
module bounded_ordered_list_checker #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [bol_pkg::FUNC_W-1:0]        func,
    input  logic signed [bol_pkg::DATA_W-1:0] value,
    input  logic                              done,
    input  logic                              found,
    input  logic [bol_pkg::STAT_W-1:0]        status,
    input  logic [bol_pkg::OCC_W-1:0]         occupancy,
    output int                                mismatches,
    output int                                outstanding,
    output int                                beats_checked,
    output int                                full_drops,
    output int                                absent_keys
);

    import bol_pkg::*;

    typedef struct packed {
        logic                 hit;
        status_t              status;
        logic [OCC_W-1:0]     occupancy;
    } list_outcome_t;

    logic signed [DATA_W-1:0] shadow_list [DEPTH];
    int                       shadow_len;
    list_outcome_t            pending_outcomes [$];
    int                       error_tally;
    int                       beat_tally;
    int                       full_tally;
    int                       absent_tally;

    // Apply one command to the shadow list and return the outcome it yields.
    function automatic list_outcome_t apply_list_op(input op_t op,
                                                    input logic signed [DATA_W-1:0] key);
        list_outcome_t res;
        int            match_at;
        res.hit    = 1'b0;
        res.status = ST_DONE;
        match_at   = -1;
        // walk from the back so the frontmost match wins
        for (int i = shadow_len - 1; i >= 0; i--)
            if (shadow_list[i] == key)
                match_at = i;
        case (op)
            OP_PUSH_FRONT:
                if (shadow_len >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = shadow_len; i > 0; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[0] = key;
                    shadow_len++;
                end
            OP_PUSH_BACK:
                if (shadow_len >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    shadow_list[shadow_len] = key;
                    shadow_len++;
                end
            OP_DELETE:
                if (match_at < 0)
                    res.status = ST_ABSENT;
                else
                begin
                    res.hit = 1'b1;
                    for (int i = match_at; i < shadow_len - 1; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            OP_SEARCH:
                if (match_at < 0)
                    res.status = ST_ABSENT;
                else
                    res.hit = 1'b1;
        endcase
        res.occupancy = OCC_W'(shadow_len);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        $display("[%0t] result beat %0d: %s expected %0h, got %0h",
                 $time, beat_tally, what, want_v, got_v);
        error_tally++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_outcome_t want;
        if (!rst_n)
        begin
            shadow_len = 0;
            pending_outcomes.delete();
            error_tally  = 0;
            beat_tally   = 0;
            full_tally   = 0;
            absent_tally = 0;
        end
        else
        begin
            // retire the result beat before taking a new command
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                    report_mismatch("unexpected result, done", 32'd0, 32'(done));
                else
                begin
                    want = pending_outcomes.pop_front();
                    beat_tally++;
                    if (found !== want.hit)
                        report_mismatch("found", 32'(want.hit), 32'(found));
                    if (status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(status));
                    if (occupancy !== want.occupancy)
                        report_mismatch("occupancy", 32'(want.occupancy), 32'(occupancy));
                end
            end
            if (start && !busy)
            begin
                want = apply_list_op(op_t'(func), value);
                if (want.status == ST_FULL)
                    full_tally++;
                if (want.status == ST_ABSENT)
                    absent_tally++;
                pending_outcomes.push_back(want);
            end
        end
        mismatches    <= error_tally;
        outstanding   <= pending_outcomes.size();
        beats_checked <= beat_tally;
        full_drops    <= full_tally;
        absent_keys   <= absent_tally;
    end

endmodule

@@ bench/bounded_ordered_list_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_unit_tb
// Drives push front, push back, delete and search commands into the bounded
// ordered list unit in bursts with random gaps; a checker beside the block
// predicts every result beat and counts mismatches, and this top gives the
// verdict.
// ----------------------------------------------------------------------------
module bounded_ordered_list_unit_tb;

    import bol_pkg::*;

    localparam int unsigned DEPTH        = 16;
    localparam int unsigned RANDOM_BEATS = 1150;
    // longest busy stretch is a full-list delete or search, plus a sender gap,
    // so this leaves a wide margin
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 40;

    localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [FUNC_W-1:0]         func;
    logic signed [DATA_W-1:0]  value;
    logic                      done;
    logic                      found;
    logic [STAT_W-1:0]         status;
    logic [OCC_W-1:0]          occupancy;

    int                        mismatches;
    int                        outstanding;
    int                        beats_checked;
    int                        full_drops;
    int                        absent_keys;
    int unsigned               quiet_cycles = 0;

    // 12 ns period, low half first
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bounded_ordered_list_unit #(
        .DEPTH      (DEPTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .value      (value),
        .done       (done),
        .found      (found),
        .status     (status),
        .occupancy  (occupancy)
    );

    bounded_ordered_list_checker #(
        .DEPTH          (DEPTH)
    ) result_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .value          (value),
        .done           (done),
        .found          (found),
        .status         (status),
        .occupancy      (occupancy),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .beats_checked  (beats_checked),
        .full_drops     (full_drops),
        .absent_keys    (absent_keys)
    );

    // Watchdog: count cycles in which neither a command beat nor a result
    // beat moves, and abort once the count reaches the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one command beat and hold it until the block takes it. Call at
    // a rising edge; returns at the edge where the beat was accepted, so a
    // following call keeps start high without a gap.
    task automatic send_cmd(input op_t op, input logic signed [DATA_W-1:0] key);
        start <= 1'b1;
        func  <= op;
        value <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [DATA_W-1:0] key_pool [8];
        logic signed [DATA_W-1:0] cmd_key;
        op_t                      cmd_op;
        int                       burst_left;
        int                       phase_left;
        int                       pick;
        bit                       filling;

        rst_n = 1'b0;
        start = 1'b0;
        func  = '0;
        value = '0;

        // Keys are drawn mostly from a small pool so that deletes and
        // searches hit often and duplicates pile up; seed the pool with the
        // extremes of the signed range.
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom;
        key_pool[0] = MOST_NEG;
        key_pool[1] = MOST_POS;
        key_pool[2] = 0;
        key_pool[3] = -1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // delete and search on an empty list: both miss
        send_cmd(OP_DELETE, 32'sd5);
        send_cmd(OP_SEARCH, 32'sd5);
        // build [MAX, MIN, MAX, 0] with a duplicate at front and inside
        send_cmd(OP_PUSH_BACK, MOST_POS);
        send_cmd(OP_PUSH_FRONT, MOST_NEG);
        send_cmd(OP_PUSH_BACK, 32'sd0);
        send_cmd(OP_PUSH_FRONT, MOST_POS);
        send_cmd(OP_SEARCH, MOST_NEG);
        // duplicates: the first delete takes the front copy, the second the
        // inner one, after which the key is gone
        send_cmd(OP_DELETE, MOST_POS);
        send_cmd(OP_DELETE, MOST_POS);
        send_cmd(OP_SEARCH, MOST_POS);
        // fill to capacity from both ends, then try to insert into a full list
        for (int i = 2; i < DEPTH; i++)
            send_cmd(op_t'(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK), (i == DEPTH - 1) ? -1 : i);
        send_cmd(OP_PUSH_FRONT, 32'sd99);
        send_cmd(OP_PUSH_BACK, 32'sd99);

        // ---- random part ----
        // Alternate fill and drain phases so the list swings between empty
        // and full many times; traffic comes in bursts with idle gaps.
        filling    = 1'b0;
        phase_left = 40;
        burst_left = 0;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (burst_left == 0)
            begin
                // drop start and scramble the payload while idle: the block
                // must ignore it
                start <= 1'b0;
                func  <= FUNC_W'($urandom);
                value <= $urandom;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                // mostly short bursts, now and then a long unbroken stretch
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 8);
            end
            if (phase_left == 0)
            begin
                filling    = !filling;
                phase_left = $urandom_range(25, 70);
                key_pool[$urandom_range(0, 7)] = $urandom;
            end

            pick = $urandom_range(0, 99);
            if (pick < (filling ? 70 : 15))
                cmd_op = op_t'($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK);
            else if (pick < (filling ? 85 : 70))
                cmd_op = OP_DELETE;
            else
                cmd_op = OP_SEARCH;

            pick = $urandom_range(0, 99);
            if (pick < 75)
                cmd_key = key_pool[$urandom_range(0, 7)];
            else if (pick < 88)
                cmd_key = $urandom;
            else
                cmd_key = $signed($urandom_range(0, 6)) - 3;

            send_cmd(cmd_op, cmd_key);
            burst_left--;
            phase_left--;
        end

        // ---- wind down ----
        // Hold start low, let the checker log the last beat, then wait out
        // every expected result and a short tail.
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d result beats over directed and random list traffic;",
                 beats_checked);
        $display("%0d inserts dropped on a full list, %0d keys absent on delete or search",
                 full_drops, absent_keys);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
